[rtl/core/tsfp_pkg.sv]
`default_nettype none
package tsfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h01;
  localparam logic [7:0] HDR_SECOND = 8'h0B;
  localparam logic [3:0] POS_HUNT   = 4'd0;
  localparam logic [3:0] POS_HDR2   = 4'd1;
  localparam logic [3:0] POS_BODY   = 4'd2;
  localparam logic [3:0] POS_PAY_LO = 4'd3;
  localparam logic [3:0] POS_PAY_HI = 4'd9;
  localparam logic [3:0] POS_LAST   = 4'd12;
  localparam int         PAY_N      = 7;
  localparam int         QUEUE_DEPTH = 2;

  localparam logic [7:0] YEAR_MAX   = 8'd99;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINSEC_MAX = 8'd59;
  localparam logic [2:0] WDAY_MAX   = 3'd6;

  // one completed frame as handed from the parser to the output stage
  typedef struct packed {
    logic       status;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] weekday_raw;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } frame_t;

endpackage
`default_nettype wire

[rtl/core/tsfp_front.sv]
`default_nettype none
module tsfp_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire  [7:0]           rx_byte,
  output logic                 push,
  output tsfp_pkg::frame_t     push_frame
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] payload [tsfp_pkg::PAY_N];
  logic       done;
  logic       frame_end;
  logic       time_ok;
  logic [7:0] month_len;
  logic [2:0] pay_idx;

  assign pay_idx = 3'(pos - tsfp_pkg::POS_PAY_LO);

  // payload order: year, month, day, weekday, hour, minute, second
  always_comb begin
    case (payload[1])
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: month_len = 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                     month_len = 8'd30;
      8'd2: month_len = (payload[0][1:0] == 2'b00) ? 8'd29 : 8'd28;
      default: month_len = 8'd0;
    endcase
  end

  assign time_ok = (payload[0] <= tsfp_pkg::YEAR_MAX)
                && (payload[1] != 8'd0) && (payload[1] <= tsfp_pkg::MONTH_MAX)
                && (payload[4] <= tsfp_pkg::HOUR_MAX)
                && (payload[5] <= tsfp_pkg::MINSEC_MAX)
                && (payload[6] <= tsfp_pkg::MINSEC_MAX)
                && (payload[2] != 8'd0) && (payload[2] <= month_len);

  // positions past the last are unreachable but still close the frame
  assign frame_end = accept && !done && (pos >= tsfp_pkg::POS_LAST);

  always_comb begin
    pos_next = pos;
    if (accept && !done) begin
      case (pos)
        tsfp_pkg::POS_HUNT: begin
          if (rx_byte == tsfp_pkg::HDR_FIRST) pos_next = tsfp_pkg::POS_HDR2;
        end
        tsfp_pkg::POS_HDR2: begin
          if (rx_byte == tsfp_pkg::HDR_SECOND) pos_next = tsfp_pkg::POS_BODY;
          else if (rx_byte == tsfp_pkg::HDR_FIRST) pos_next = tsfp_pkg::POS_HDR2;
          else pos_next = tsfp_pkg::POS_HUNT;
        end
        default: begin
          if (pos >= tsfp_pkg::POS_LAST) pos_next = tsfp_pkg::POS_HUNT;
          else pos_next = pos + 4'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= tsfp_pkg::POS_HUNT;
      done <= 1'b0;
    end else begin
      pos <= pos_next;
      if (frame_end && time_ok) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !done && pos >= tsfp_pkg::POS_PAY_LO && pos <= tsfp_pkg::POS_PAY_HI) begin
      payload[pay_idx] <= rx_byte;
    end
  end

  assign push = frame_end;

  always_comb begin
    push_frame.status      = !time_ok;
    push_frame.year        = payload[0];
    push_frame.month       = payload[1];
    push_frame.day         = payload[2];
    push_frame.weekday_raw = payload[3];
    push_frame.hour        = payload[4];
    push_frame.minute      = payload[5];
    push_frame.second      = payload[6];
  end

endmodule
`default_nettype wire

[rtl/core/tsfp_queue.sv]
`default_nettype none
module tsfp_queue #(
  parameter int DEPTH = tsfp_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  tsfp_pkg::frame_t     push_frame,
  input  wire                  pop,
  output logic                 not_empty,
  output logic                 full,
  output tsfp_pkg::frame_t     head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsfp_pkg::frame_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_frame;
  end

endmodule
`default_nettype wire

[rtl/core/tsfp_back.sv]
`default_nettype none
module tsfp_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_not_empty,
  input  tsfp_pkg::frame_t     q_head,
  output logic                 q_pop,
  output logic                 res_valid,
  input  wire                  res_ready,
  output logic                 status,
  output logic [7:0]           year,
  output logic [7:0]           month,
  output logic [7:0]           day,
  output logic [2:0]           weekday,
  output logic [7:0]           hour,
  output logic [7:0]           minute,
  output logic [7:0]           second
);

  logic load;

  assign load  = q_not_empty && (!res_valid || res_ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= q_head.status;
      year   <= q_head.year;
      month  <= q_head.month;
      day    <= q_head.day;
      // out-of-range weekday codes fold to 0
      weekday <= (q_head.weekday_raw <= 8'(tsfp_pkg::WDAY_MAX)) ?
                 q_head.weekday_raw[2:0] : 3'd0;
      hour   <= q_head.hour;
      minute <= q_head.minute;
      second <= q_head.second;
    end
  end

endmodule
`default_nettype wire

[rtl/core/time_sync_frame_parser.sv]
`default_nettype none
// Hunts a byte stream for 13-byte time frames (header 01 0B) and returns one result word per
// completed frame: year, month, day, weekday, hour, minute, second and a status bit (0 good time,
// 1 bad time). One byte word is taken every cycle; rx_ready drops only when the two-entry result
// queue is full, which needs the result side to stall across two whole frames. The edge that
// takes the thirteenth byte writes the queue; the word then moves from the queue into the output
// register once that register is empty or being read by res_ready. After the first good frame all
// further bytes are taken and ignored until reset.
module time_sync_frame_parser #(
  parameter int QUEUE_DEPTH = tsfp_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        rx_valid,
  output logic       rx_ready,
  input  wire  [7:0] rx_byte,
  output logic       res_valid,
  input  wire        res_ready,
  output logic       status,
  output logic [7:0] year,
  output logic [7:0] month,
  output logic [7:0] day,
  output logic [2:0] weekday,
  output logic [7:0] hour,
  output logic [7:0] minute,
  output logic [7:0] second
);

  logic             accept;
  logic             push;
  tsfp_pkg::frame_t push_frame;
  logic             q_pop;
  logic             q_not_empty;
  logic             q_full;
  tsfp_pkg::frame_t q_head;

  assign rx_ready = !q_full;
  assign accept   = rx_valid && rx_ready;

  tsfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_frame (push_frame)
  );

  tsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .full       (q_full),
    .head       (q_head)
  );

  tsfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .status      (status),
    .year        (year),
    .month       (month),
    .day         (day),
    .weekday     (weekday),
    .hour        (hour),
    .minute      (minute),
    .second      (second)
  );

endmodule
`default_nettype wire

[rtl/core/tsfp_checker.sv]
`default_nettype none
module tsfp_checker (
  input wire       clk,
  input wire       rst,
  input wire       res_valid,
  input wire       res_ready,
  input wire       status,
  input wire [7:0] year,
  input wire [7:0] month,
  input wire [7:0] day,
  input wire [2:0] weekday,
  input wire [7:0] hour,
  input wire [7:0] minute,
  input wire [7:0] second
);

  // a held result word keeps its status, year and second
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(year)
      && $stable(second))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_wday: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> weekday <= 3'd6)
    else $error("weekday out of range");

  // good status implies every field in range
  a_good: assert property (@(posedge clk) disable iff (rst)
    res_valid && !status |-> year <= 8'd99 && month != 8'd0 && month <= 8'd12
      && day != 8'd0 && day <= 8'd31 && hour <= 8'd23 && minute <= 8'd59
      && second <= 8'd59)
    else $error("good status on bad time");

  // at most one good frame per reset
  a_once: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !status |=> !res_valid || status)
    else $error("second good frame after done");

endmodule

bind time_sync_frame_parser tsfp_checker u_tsfp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .status    (status),
  .year      (year),
  .month     (month),
  .day       (day),
  .weekday   (weekday),
  .hour      (hour),
  .minute    (minute),
  .second    (second)
);
`default_nettype wire

[tb/time_sync_frame_parser_test.sv]
`default_nettype none
module time_sync_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  // raw frame bytes 3..9 as sent on the link
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] weekday;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } raw_time_t;

  // one result word as the block should present it
  typedef struct packed {
    logic       status;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [2:0] weekday;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } time_result_t;

  localparam int HOLD_CYCLES = 160;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic       status;
  logic [7:0] year;
  logic [7:0] month;
  logic [7:0] day;
  logic [2:0] weekday;
  logic [7:0] hour;
  logic [7:0] minute;
  logic [7:0] second;

  time_sync_frame_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status),
    .year      (year),
    .month     (month),
    .day       (day),
    .weekday   (weekday),
    .hour      (hour),
    .minute    (minute),
    .second    (second)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  time_result_t expected_times[$];

  // parser mirror
  logic [3:0] frame_pos;
  logic [7:0] pay_bytes [tsfp_pkg::PAY_N];
  bit         synced;

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_served = 0;
  int hold_left = 0;
  int words_sent;
  int frames_checked;
  int bad_frames_seen;
  int errors;

  function automatic int unsigned days_in_month(logic [7:0] yr, logic [7:0] mo);
    case (mo)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 31;
      8'd4, 8'd6, 8'd9, 8'd11: return 30;
      8'd2: return (yr[1:0] == 2'b00) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic bit time_is_good(raw_time_t t);
    if (t.year > tsfp_pkg::YEAR_MAX) return 1'b0;
    if (t.month < 8'd1 || t.month > tsfp_pkg::MONTH_MAX) return 1'b0;
    if (t.hour > tsfp_pkg::HOUR_MAX) return 1'b0;
    if (t.minute > tsfp_pkg::MINSEC_MAX || t.second > tsfp_pkg::MINSEC_MAX) return 1'b0;
    if (t.day < 8'd1 || t.day > days_in_month(t.year, t.month)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic track_frame_word(input logic [7:0] b);
    logic [3:0]   nxt;
    raw_time_t    t;
    time_result_t r;
    if (synced) return;
    if (frame_pos == tsfp_pkg::POS_HUNT) begin
      if (b == tsfp_pkg::HDR_FIRST) frame_pos = tsfp_pkg::POS_HDR2;
      return;
    end
    if (frame_pos == tsfp_pkg::POS_HDR2) begin
      if (b == tsfp_pkg::HDR_SECOND) frame_pos = tsfp_pkg::POS_BODY;
      else if (b != tsfp_pkg::HDR_FIRST) frame_pos = tsfp_pkg::POS_HUNT;
      return;
    end
    if (frame_pos >= tsfp_pkg::POS_PAY_LO && frame_pos <= tsfp_pkg::POS_PAY_HI)
      pay_bytes[3'(frame_pos - tsfp_pkg::POS_PAY_LO)] = b;
    nxt = frame_pos + 4'd1;
    if (nxt <= tsfp_pkg::POS_LAST && nxt != 4'd0) begin
      frame_pos = nxt;
      return;
    end
    frame_pos = tsfp_pkg::POS_HUNT;
    t = {pay_bytes[0], pay_bytes[1], pay_bytes[2], pay_bytes[3],
         pay_bytes[4], pay_bytes[5], pay_bytes[6]};
    r.status  = !time_is_good(t);
    r.year    = t.year;
    r.month   = t.month;
    r.day     = t.day;
    r.weekday = (t.weekday > tsfp_pkg::WDAY_MAX) ? 3'd0 : t.weekday[2:0];
    r.hour    = t.hour;
    r.minute  = t.minute;
    r.second  = t.second;
    if (!r.status) synced = 1'b1;
    expected_times.push_back(r);
  endtask

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    words_sent++;
    track_frame_word(b);
  endtask

  task automatic send_time_frame(input raw_time_t t, input bit extra_hdr);
    if (extra_hdr) repeat ($urandom_range(1, 2)) send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_SECOND);
    send_word(8'($urandom_range(255)));
    send_word(t.year);
    send_word(t.month);
    send_word(t.day);
    send_word(t.weekday);
    send_word(t.hour);
    send_word(t.minute);
    send_word(t.second);
    repeat (3) send_word(8'($urandom_range(255)));
  endtask

  // leans towards the ends of the range
  function automatic logic [7:0] pick_in(int lo, int hi);
    case ($urandom_range(5))
      0: return 8'(lo);
      1: return 8'(hi);
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic raw_time_t random_time();
    raw_time_t t;
    t.year    = pick_in(0, 99);
    t.month   = pick_in(1, 12);
    t.day     = pick_in(1, days_in_month(t.year, t.month));
    t.weekday = $urandom_range(1) ? pick_in(0, 7) : 8'($urandom_range(255));
    t.hour    = pick_in(0, 23);
    t.minute  = pick_in(0, 59);
    t.second  = pick_in(0, 59);
    return t;
  endfunction

  // breaks one or two fields, often just past the limit
  function automatic raw_time_t corrupt_time(raw_time_t t);
    bit edge_val;
    repeat ($urandom_range(1, 2)) begin
      edge_val = $urandom_range(1);
      case ($urandom_range(5))
        0: t.year = edge_val ? 8'd100 : pick_in(100, 255);
        1: t.month = edge_val ? ($urandom_range(1) ? 8'd0 : 8'd13) : pick_in(13, 255);
        2: t.day = edge_val ? ($urandom_range(1) ? 8'd0
                                : 8'(days_in_month(t.year, t.month) + 1))
                            : pick_in(32, 255);
        3: t.hour = edge_val ? 8'd24 : pick_in(24, 255);
        4: t.minute = edge_val ? 8'd60 : pick_in(60, 255);
        default: t.second = edge_val ? 8'd60 : pick_in(60, 255);
      endcase
    end
    return t;
  endfunction

  task automatic check_field(input string label, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      res_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    time_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_times.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result word, status %0d %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                   $time, status, year, month, day, weekday, hour, minute, second);
      end else begin
        want = expected_times.pop_front();
        frames_checked++;
        if (want.status) bad_frames_seen++;
        check_field("status", 8'(want.status), 8'(status));
        check_field("year", want.year, year);
        check_field("month", want.month, month);
        check_field("day", want.day, day);
        check_field("weekday", 8'(want.weekday), 8'(weekday));
        check_field("hour", want.hour, hour);
        check_field("minute", want.minute, minute);
        check_field("second", want.second, second);
      end
    end
  end

  // noise, a dropped header, repeated 0x01, then an all-bad frame
  task automatic test_header_hunt();
    idle_pct  = 0;
    stall_pct = 0;
    send_word(8'h00);
    send_word(8'hFF);
    send_word(tsfp_pkg::HDR_SECOND);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(8'h02);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_SECOND);
    send_word(tsfp_pkg::HDR_FIRST);
    repeat (7) send_word(8'hFF);
    send_word(8'h00);
    send_word(tsfp_pkg::HDR_FIRST);
    send_word(tsfp_pkg::HDR_SECOND);
  endtask

  task automatic test_random_traffic(input int n_words, input int sender_idle,
                                     input int rcv_stall);
    int start;
    int pick;
    idle_pct  = sender_idle;
    stall_pct = rcv_stall;
    start     = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_time_frame(corrupt_time(random_time()), $urandom_range(4) == 0);
      end else if (pick < 88) begin
        send_word(tsfp_pkg::HDR_FIRST);
        send_word(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 5)) send_word(8'($urandom_range(255)));
      end
    end
  endtask

  // result side held off long enough for the queue to fill and stall rx
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (12) send_time_frame(corrupt_time(random_time()), 1'b0);
  endtask

  // first good frame latches done; everything after is dropped
  task automatic test_lock_after_sync();
    raw_time_t t;
    idle_pct  = 22;
    stall_pct = 22;
    case ($urandom_range(2))
      0: t = {8'd0, 8'd2, 8'd29, 8'd6, 8'd23, 8'd59, 8'd59};
      1: t = {8'd99, 8'd12, 8'd31, 8'd7, 8'd0, 8'd0, 8'd0};
      default: t = random_time();
    endcase
    send_time_frame(t, 1'b0);
    send_time_frame(random_time(), 1'b0);
    repeat (25) send_word(8'($urandom_range(255)));
  endtask

  initial begin
    int waited;
    frame_pos       = tsfp_pkg::POS_HUNT;
    synced          = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_requests   = 0;
    words_sent      = 0;
    frames_checked  = 0;
    bad_frames_seen = 0;
    errors          = 0;
    foreach (pay_bytes[i]) pay_bytes[i] = 8'h00;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_hunt();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 84, 0);
    test_random_traffic(150, 0, 84);
    test_random_traffic(150, 22, 22);
    test_backpressure();
    test_lock_after_sync();

    @(negedge clk);
    rx_valid <= 1'b0;
    waited = 0;
    while (expected_times.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_times.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, expected_times.size());
    end

    $display("Sent %0d bytes over four idle/stall mixes plus a long result hold-off;",
             words_sent);
    $display("checked %0d frames, %0d with bad time; sync lock %s.", frames_checked,
             bad_frames_seen, synced ? "reached" : "not reached");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Run timed out at %0t", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/core/tsfp_pkg.sv
rtl/core/tsfp_front.sv
rtl/core/tsfp_queue.sv
rtl/core/tsfp_back.sv
rtl/core/time_sync_frame_parser.sv
rtl/core/tsfp_checker.sv
tb/time_sync_frame_parser_test.sv
